// ===== src/stip_pkg.sv =====
`default_nettype none

package stip_pkg;

   // Configuration
   localparam logic [5:0] BASE_RESET = 6'd10;
   localparam logic [5:0] BASE_MAX   = 6'd36;
   localparam logic [5:0] BASE_OCT   = 6'd8;
   localparam logic [5:0] BASE_DEC   = 6'd10;
   localparam logic [5:0] BASE_HEX   = 6'd16;
   localparam logic [5:0] BASE_AUTO  = 6'd0;
   localparam logic [5:0] BASE_BAD   = 6'd1;

   // Digit code for a character that is no digit in any base
   localparam logic [5:0] NO_DIGIT = 6'h3F;

   // Character codes
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_NINE       = 8'h39;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CH_UPPER_X    = 8'h58;
   localparam logic [7:0] CH_LOWER_X    = 8'h78;
   localparam logic [7:0] CH_UPPER_BIAS = 8'd55;  // 'A' - 10
   localparam logic [7:0] CH_LOWER_BIAS = 8'd87;  // 'a' - 10

   localparam int RSP_VALUE_BITS = 32;

   // One classified character
   typedef struct packed {
      logic [5:0] digit;
      logic       is_space;
      logic       is_minus;
      logic       is_plus;
      logic       is_zero;
      logic       is_x;
      logic       first;
      logic       last;
      logic [5:0] base;
      logic       base_bad;
   } item_type;

   typedef struct packed {
      logic [RSP_VALUE_BITS-1:0] value;
      logic                      overflowed;
      logic                      had_digits;
   } result_type;

endpackage

`default_nettype wire

// ===== src/stip_queue.sv =====
`default_nettype none

module stip_queue #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

   logic [WIDTH-1:0]    mem [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      // wrap at the last entry so any depth works
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("queue count above depth");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> !empty)
      else $error("queue empty after a lone push");

   a_pop_frees: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> !full)
      else $error("queue full after a lone pop");

endmodule

`default_nettype wire

// ===== src/stip_front.sv =====
`default_nettype none

module stip_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic [5:0]       csr_number_base,
   input  wire logic             req_push,
   input  wire logic [7:0]       req_ch,
   input  wire logic             req_first,
   input  wire logic             req_last,
   input  wire logic             item_full,
   output logic                  item_push,
   output stip_pkg::item_type    item
);

   import stip_pkg::*;

   logic [5:0] base_ff, base_in;
   logic [7:0] biased;

   assign base_in   = csr_write_enable ? csr_number_base : base_ff;
   assign item_push = req_push && !item_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
      end else begin
         base_ff <= base_in;
      end
   end

   always_comb begin
      biased = 8'd0;
      priority if (req_ch >= CH_ZERO && req_ch <= CH_NINE) begin
         biased = req_ch - CH_ZERO;
      end else if (req_ch >= CH_UPPER_A && req_ch <= CH_UPPER_Z) begin
         biased = req_ch - CH_UPPER_BIAS;
      end else if (req_ch >= CH_LOWER_A && req_ch <= CH_LOWER_Z) begin
         biased = req_ch - CH_LOWER_BIAS;
      end else begin
         biased = {2'b00, NO_DIGIT};
      end

      item.digit    = biased[5:0];
      item.is_space = (req_ch == CH_SPACE);
      item.is_minus = (req_ch == CH_MINUS);
      item.is_plus  = (req_ch == CH_PLUS);
      item.is_zero  = (req_ch == CH_ZERO);
      item.is_x     = (req_ch == CH_LOWER_X) || (req_ch == CH_UPPER_X);
      item.first    = req_first;
      item.last     = req_last;
      // latch the base with each item; the back takes it only at a first
      item.base     = base_ff;
      item.base_bad = (base_ff == BASE_BAD) || (base_ff > BASE_MAX);
   end

endmodule

`default_nettype wire

// ===== src/stip_back.sv =====
`default_nettype none

module stip_back #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire stip_pkg::item_type  item,
   input  wire logic                item_empty,
   output logic                     item_pop,
   input  wire logic                res_full,
   output logic                     res_push,
   output stip_pkg::result_type     res
);

   import stip_pkg::*;

   localparam int SUM_BITS = VALUE_BITS + 7;
   localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      PH_FINISHED,
      PH_LEAD,
      PH_SIGNED,
      PH_ZERO,
      PH_DIGITS
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  neg_ff, neg_in;
   logic [5:0]            base_ff, base_in;
   logic                  ds_ff, ds_in;
   logic                  ov_ff, ov_in;

   logic                  emit;
   logic                  bad_now;
   logic                  start;
   logic                  take;
   logic [VALUE_BITS-1:0] limit;
   logic [SUM_BITS-1:0]   sum;
   logic [VALUE_BITS-1:0] res_value;
   logic [RSP_VALUE_BITS-1:0] res_value32;

   assign item_pop = !item_empty && !res_full;
   assign res_push = item_pop && emit;

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      base_in  = base_ff;
      ds_in    = ds_ff;
      ov_in    = ov_ff;
      emit     = 1'b0;
      bad_now  = 1'b0;
      start    = 1'b0;
      take     = 1'b0;
      limit    = VMAX;
      sum      = '0;

      if (item.first) begin
         acc_in   = '0;
         neg_in   = 1'b0;
         ds_in    = 1'b0;
         ov_in    = 1'b0;
         base_in  = item.base;
         phase_in = PH_LEAD;
         if (item.base_bad) begin
            // invalid base: report zero at once, drop the rest of the string
            base_in  = BASE_AUTO;
            phase_in = PH_FINISHED;
            bad_now  = 1'b1;
            emit     = 1'b1;
         end
      end

      if (!bad_now && phase_in != PH_FINISHED) begin
         unique case (phase_in)
            PH_LEAD: begin
               priority if (item.is_space) begin
                  phase_in = PH_LEAD;
               end else if (item.is_minus) begin
                  neg_in   = 1'b1;
                  phase_in = PH_SIGNED;
               end else if (item.is_plus) begin
                  phase_in = PH_SIGNED;
               end else begin
                  start = 1'b1;
               end
            end
            PH_SIGNED: start = 1'b1;
            PH_ZERO: begin
               if (item.is_x) begin
                  base_in  = BASE_HEX;
                  phase_in = PH_DIGITS;
               end else begin
                  take = 1'b1;
               end
            end
            PH_DIGITS:   take = 1'b1;
            PH_FINISHED: take = 1'b0;
            default:     take = 1'b1;
         endcase

         if (start) begin
            if (item.is_zero && (base_in == BASE_AUTO || base_in == BASE_HEX)) begin
               // leading zero counts as a digit and may open a 0x prefix
               ds_in    = 1'b1;
               acc_in   = '0;
               base_in  = (base_in == BASE_AUTO) ? BASE_OCT : BASE_HEX;
               phase_in = PH_ZERO;
            end else begin
               if (base_in == BASE_AUTO) begin
                  base_in = BASE_DEC;
               end
               take = 1'b1;
            end
         end

         if (take) begin
            phase_in = PH_DIGITS;
            if (item.digit >= base_in) begin
               emit = 1'b1;
            end else begin
               ds_in = 1'b1;
               limit = neg_in ? VMIN : VMAX;
               sum   = SUM_BITS'(acc_in) * SUM_BITS'(base_in) + SUM_BITS'(item.digit);
               if (!ov_in) begin
                  if (sum > SUM_BITS'(limit)) begin
                     ov_in = 1'b1;
                  end else begin
                     acc_in = sum[VALUE_BITS-1:0];
                  end
               end
            end
         end

         if (item.last) begin
            emit = 1'b1;
         end
         if (emit) begin
            phase_in = PH_FINISHED;
         end
      end

      priority if (ov_in) begin
         res_value = neg_in ? VMIN : VMAX;
      end else if (neg_in) begin
         res_value = '0 - acc_in;
      end else begin
         res_value = acc_in;
      end
   end

   if (VALUE_BITS >= RSP_VALUE_BITS) begin : g_trunc
      assign res_value32 = res_value[RSP_VALUE_BITS-1:0];
   end else begin : g_ext
      assign res_value32 = {{(RSP_VALUE_BITS-VALUE_BITS){1'b0}}, res_value};
   end

   assign res.value      = res_value32;
   assign res.overflowed = ov_in;
   assign res.had_digits = ds_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FINISHED;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         base_ff  <= BASE_AUTO;
         ds_ff    <= 1'b0;
         ov_ff    <= 1'b0;
      end else if (item_pop) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         base_ff  <= base_in;
         ds_ff    <= ds_in;
         ov_ff    <= ov_in;
      end
   end

   a_emit_finishes: assert property (@(posedge clock) disable iff (reset)
      res_push |=> phase_ff == PH_FINISHED)
      else $error("parser still active after a result");

   a_saturate: assert property (@(posedge clock) disable iff (reset)
      (res_push && ov_in) |-> (res_value == VMAX || res_value == VMIN))
      else $error("overflowed result not saturated");

   a_no_digit_zero: assert property (@(posedge clock) disable iff (reset)
      (res_push && !ds_in) |-> (res_value == '0 && !ov_in))
      else $error("result without digits is not zero");

endmodule

`default_nettype wire

// ===== src/string_to_integer_parser.sv =====
// Channel   Ports                                          Handshake
// req       req_ch, req_first, req_last                    req_push, req_full
// rsp       rsp_value, rsp_overflowed, rsp_had_digits      rsp_pop, rsp_empty
// csr       csr_number_base                                csr_write_enable
//
// Takes one character per cycle while req_full is low; the back does one
// multiply-add by the base and a limit compare per character.
// A result shows on the rsp side after its ending character has passed the item queue
// and the back and the result has been written into the result queue.
// Reset is synchronous: both queues empty, base register set to 10.
// req_full rises when QUEUE_DEPTH items wait for the back; the back stalls only
// while QUEUE_DEPTH results wait to be popped.
`default_nettype none

module string_to_integer_parser #(
   parameter int VALUE_BITS  = 32,
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [5:0]  csr_number_base,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_first,
   input  wire logic        req_last,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic signed [31:0] rsp_value,
   output logic             rsp_overflowed,
   output logic             rsp_had_digits
);

   import stip_pkg::*;

   item_type   front_item;
   item_type   back_item;
   result_type back_res;
   result_type out_res;
   logic       item_push;
   logic       item_full;
   logic       item_empty;
   logic       item_pop;
   logic       res_push;
   logic       res_full;

   stip_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_number_base  (csr_number_base),
      .req_push         (req_push),
      .req_ch           (req_ch),
      .req_first        (req_first),
      .req_last         (req_last),
      .item_full        (item_full),
      .item_push        (item_push),
      .item             (front_item)
   );

   stip_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH ($bits(item_type))
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (item_push),
      .push_data (front_item),
      .full      (item_full),
      .pop       (item_pop),
      .pop_data  (back_item),
      .empty     (item_empty)
   );

   stip_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (back_item),
      .item_empty (item_empty),
      .item_pop   (item_pop),
      .res_full   (res_full),
      .res_push   (res_push),
      .res        (back_res)
   );

   stip_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH ($bits(result_type))
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (back_res),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (out_res),
      .empty     (rsp_empty)
   );

   assign req_full       = item_full;
   assign rsp_value      = out_res.value;
   assign rsp_overflowed = out_res.overflowed;
   assign rsp_had_digits = out_res.had_digits;

endmodule

`default_nettype wire
